### src/psa_pkg.sv
// Shared types, widths and codes for the packed slot allocator.
`default_nettype none

package psa_pkg;

    // Field widths fixed by the item layout.
    localparam int HANDLE_W   = 10;
    localparam int SLOT_OUT_W = 10;
    localparam int SLOT_W     = 11;
    localparam int CAP_W      = 11;
    localparam int RSV_W      = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // One handle table entry: live flag above the slot number.
    localparam int HENT_W = SLOT_W + 1;

    // Default table depths.
    localparam int DEF_MAX_SLOTS   = 1024;
    localparam int DEF_MAX_HANDLES = 1024;

    // Register reset values.
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [RSV_W-1:0] RSV_RESET = 10'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'd1;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ALREADY   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FIX
    } state_t;

    typedef struct packed {
        logic                op;
        logic [HANDLE_W-1:0] handle;
    } psa_req_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  moved;
        logic [HANDLE_W-1:0]   moved_handle;
        logic [SLOT_W-1:0]     fill_level;
    } psa_rsp_t;

endpackage

`default_nettype wire

### src/packed_slot_allocator.sv
// Top level of the packed slot allocator: control sequencer and the two tables.
`default_nettype none

// The allocator keeps handles packed in a slot table above a block of reserved
// slots, and a per-handle index of each handle's slot. An allocate passes
// through EXEC after IDLE, and so does a free whose slot was the last occupied
// one; a free that moves the last slot's owner into the hole also passes
// through FIX, because the handle index memory has one write port and must be
// written for both the freed handle and the moved one. Each item first reads
// both memories through their registered read ports, then decides and writes
// back. After reset, and after every write of reserved_slots, the handle index
// is swept clean over all MAX_HANDLES entries (1024 by default), during which
// no item is taken; configuration writes are still accepted. A finished result
// sits in an output register, so the next item can be taken while it waits.
module packed_slot_allocator #(
    parameter int MAX_SLOTS   = psa_pkg::DEF_MAX_SLOTS,
    parameter int MAX_HANDLES = psa_pkg::DEF_MAX_HANDLES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire psa_pkg::psa_req_t              req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output psa_pkg::psa_rsp_t                   rsp,
    input  wire logic                           cfg_we,
    input  wire logic [psa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int HADDR_W = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
    localparam logic [HADDR_W-1:0] CLR_LAST = HADDR_W'(MAX_HANDLES - 1);
    // A table deeper than the capacity register can express is limited by the register.
    localparam int CAP_MAX = (1 << psa_pkg::CAP_W) - 1;
    localparam logic [psa_pkg::CAP_W-1:0] SLOTS_CAP =
        psa_pkg::CAP_W'((MAX_SLOTS > CAP_MAX) ? CAP_MAX : MAX_SLOTS);

    // Control and configuration state.
    psa_pkg::state_t              state_reg, state_next;
    logic [psa_pkg::CAP_W-1:0]    capacity_reg;
    logic [psa_pkg::SLOT_W-1:0]   fill_mark_reg;
    logic [HADDR_W-1:0]           clr_cnt_reg;
    logic                         rsp_valid_reg;

    // Item and result registers.
    logic                          op_reg;
    logic [psa_pkg::HANDLE_W-1:0]  handle_reg;
    logic [psa_pkg::HANDLE_W-1:0]  fix_handle_reg;
    logic [psa_pkg::SLOT_W-1:0]    fix_slot_reg;
    psa_pkg::psa_rsp_t             rsp_reg;

    // Memory ports.
    logic                          h_wr_en, s_wr_en;
    logic [HADDR_W-1:0]            h_wr_addr, h_rd_addr;
    logic [SADDR_W-1:0]            s_wr_addr, s_rd_addr;
    logic [psa_pkg::HENT_W-1:0]    h_wr_data, h_rd_data;
    logic [psa_pkg::HANDLE_W-1:0]  s_wr_data, s_rd_data;

    // Decode results.
    logic                          accept;
    logic                          out_free;
    logic                          cfg_cap_wr, cfg_rsv_wr;
    logic                          rsp_load;
    logic                          fix_load;
    psa_pkg::psa_rsp_t             rsp_next;
    logic [psa_pkg::SLOT_W-1:0]    fill_exec;
    logic [psa_pkg::CAP_W-1:0]     eff_cap;
    logic [psa_pkg::CAP_W-1:0]     new_cap_eff;
    logic                          in_range;
    logic                          fix_in_range;
    logic                          ent_live;
    logic [psa_pkg::SLOT_W-1:0]    ent_slot;
    logic [psa_pkg::SLOT_W-1:0]    last_slot;

    // Memory holding each handle's live flag and slot.
    psa_ram #(
        .WIDTH (psa_pkg::HENT_W),
        .DEPTH (MAX_HANDLES)
    ) u_handle_ram (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (h_wr_data),
        .rd_en   (accept),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    // Memory holding the owner of each slot.
    psa_ram #(
        .WIDTH (psa_pkg::HANDLE_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (s_wr_addr),
        .wr_data (s_wr_data),
        .rd_en   (accept),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

    // Handshake and configuration decode.
    assign req_stall = (state_reg != psa_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        cfg_cap_wr = 1'b0;
        cfg_rsv_wr = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                psa_pkg::REG_CAPACITY: cfg_cap_wr = 1'b1;
                psa_pkg::REG_RESERVED: cfg_rsv_wr = 1'b1;
            endcase
        end
    end

    // Effective capacity of the stored limit and of a newly written one.
    assign eff_cap     = (capacity_reg > SLOTS_CAP) ? SLOTS_CAP : capacity_reg;
    assign new_cap_eff = (cfg_data > SLOTS_CAP) ? SLOTS_CAP : cfg_data;

    // Read addresses: the item's handle and the last occupied slot.
    assign h_rd_addr = HADDR_W'(req.handle);
    assign last_slot = fill_mark_reg - psa_pkg::SLOT_W'(1);
    assign s_rd_addr = SADDR_W'(last_slot);

    assign in_range     = 32'(handle_reg) < MAX_HANDLES;
    assign fix_in_range = 32'(fix_handle_reg) < MAX_HANDLES;
    assign ent_live     = h_rd_data[psa_pkg::SLOT_W];
    assign ent_slot     = h_rd_data[psa_pkg::SLOT_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psa_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = psa_pkg::S_IDLE;
                end
            end
            psa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = psa_pkg::S_EXEC;
                end
            end
            psa_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = fix_load ? psa_pkg::S_FIX : psa_pkg::S_IDLE;
                end
            end
            psa_pkg::S_FIX:
            begin
                state_next = psa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = psa_pkg::S_IDLE;
            end
        endcase
        if (cfg_rsv_wr)
        begin
            state_next = psa_pkg::S_CLEAR;
        end
    end

    // Decision and write-back for the current item.
    always_comb
    begin
        h_wr_en   = 1'b0;
        h_wr_addr = clr_cnt_reg;
        h_wr_data = '0;
        s_wr_en   = 1'b0;
        s_wr_addr = '0;
        s_wr_data = '0;
        rsp_load  = 1'b0;
        fix_load  = 1'b0;
        fill_exec = fill_mark_reg;
        rsp_next  = '{status: psa_pkg::ST_OK, slot: '0, moved: 1'b0,
                      moved_handle: '0, fill_level: '0};
        unique case (state_reg)
            psa_pkg::S_CLEAR:
            begin
                h_wr_en = 1'b1;
            end
            psa_pkg::S_EXEC:
            begin
                if (op_reg == psa_pkg::OP_ALLOC)
                begin
                    if (!in_range)
                    begin
                        rsp_next.status = psa_pkg::ST_FULL;
                    end
                    else if (ent_live)
                    begin
                        rsp_next.status = psa_pkg::ST_ALREADY;
                        rsp_next.slot   = psa_pkg::SLOT_OUT_W'(ent_slot);
                    end
                    else if (fill_mark_reg >= eff_cap)
                    begin
                        rsp_next.status = psa_pkg::ST_FULL;
                    end
                    else
                    begin
                        rsp_next.slot = psa_pkg::SLOT_OUT_W'(fill_mark_reg);
                        h_wr_en       = out_free;
                        h_wr_addr     = HADDR_W'(handle_reg);
                        h_wr_data     = {1'b1, fill_mark_reg};
                        s_wr_en       = out_free;
                        s_wr_addr     = SADDR_W'(fill_mark_reg);
                        s_wr_data     = handle_reg;
                        fill_exec     = fill_mark_reg + psa_pkg::SLOT_W'(1);
                    end
                end
                else
                begin
                    if (!in_range || !ent_live || (fill_mark_reg == '0))
                    begin
                        rsp_next.status = psa_pkg::ST_NOT_ALLOC;
                    end
                    else
                    begin
                        rsp_next.slot = psa_pkg::SLOT_OUT_W'(ent_slot);
                        h_wr_en       = out_free;
                        h_wr_addr     = HADDR_W'(handle_reg);
                        h_wr_data     = '0;
                        // Fill the hole with the last slot's owner.
                        if (ent_slot != last_slot)
                        begin
                            s_wr_en               = out_free;
                            s_wr_addr             = SADDR_W'(ent_slot);
                            s_wr_data             = s_rd_data;
                            rsp_next.moved        = 1'b1;
                            rsp_next.moved_handle = s_rd_data;
                            fix_load              = 1'b1;
                        end
                        fill_exec = last_slot;
                    end
                end
                rsp_next.fill_level = fill_exec;
                rsp_load            = out_free;
            end
            psa_pkg::S_FIX:
            begin
                // Point the moved handle at its new slot.
                h_wr_en   = fix_in_range;
                h_wr_addr = HADDR_W'(fix_handle_reg);
                h_wr_data = {1'b1, fix_slot_reg};
            end
            default:
            begin
                h_wr_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psa_pkg::S_CLEAR;
            capacity_reg  <= psa_pkg::CAP_RESET;
            fill_mark_reg <= psa_pkg::SLOT_W'(psa_pkg::RSV_RESET);
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Capacity writes below the fill mark are dropped.
            if (cfg_cap_wr && (new_cap_eff >= fill_mark_reg))
            begin
                capacity_reg <= cfg_data;
            end

            // Reserved writes start a fresh table.
            if (cfg_rsv_wr)
            begin
                fill_mark_reg <= ({1'b0, psa_pkg::RSV_W'(cfg_data)} > eff_cap)
                                 ? eff_cap : {1'b0, psa_pkg::RSV_W'(cfg_data)};
            end
            else if (rsp_load)
            begin
                fill_mark_reg <= fill_exec;
            end

            // Sweep counter for the handle table clear.
            if (cfg_rsv_wr)
            begin
                clr_cnt_reg <= '0;
            end
            else if (state_reg == psa_pkg::S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + HADDR_W'(1);
            end

            // Output register handshake.
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.op;
            handle_reg <= req.handle;
        end
        if (fix_load && out_free && (state_reg == psa_pkg::S_EXEC))
        begin
            fix_handle_reg <= s_rd_data;
            fix_slot_reg   <= ent_slot;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

### src/psa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sim/psa_checker.sv
`timescale 1ns / 1ps
// Result checker for the packed slot allocator: predicts every result and compares it.
module psa_checker
    import psa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_stall,
    input  wire psa_req_t              req,
    input  wire logic                  rsp_valid,
    input  wire logic                  rsp_stall,
    input  wire psa_rsp_t              rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending
);

    localparam int SLOTS   = DEF_MAX_SLOTS;
    localparam int HANDLES = DEF_MAX_HANDLES;

    // Shadow copy of the allocator tables and registers.
    logic [HANDLE_W-1:0] owner_of_slot [SLOTS];
    logic [SLOT_W-1:0]   slot_of_handle [HANDLES];
    logic                handle_live [HANDLES];
    int unsigned         fill_mark;
    int unsigned         cap_limit;
    int unsigned         rsv_count;

    // Results still owed by the block, oldest first.
    psa_rsp_t owed_results[$];

    // Capacity above the table depth behaves as the table depth.
    function automatic int unsigned usable_slots();
        return (cap_limit > SLOTS) ? SLOTS : cap_limit;
    endfunction

    // A fresh table: no handle is live and the fill mark sits on the reserved block.
    function automatic void clear_table();
        for (int i = 0; i < HANDLES; i++)
        begin
            handle_live[i]    = 1'b0;
            slot_of_handle[i] = '0;
        end
        fill_mark = (rsv_count > usable_slots()) ? usable_slots() : rsv_count;
    endfunction

    // A capacity below the fill mark is refused; a reserved count restarts the table.
    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        int unsigned value;
        int unsigned capped;
        value = int'(data);
        if (idx == REG_CAPACITY)
        begin
            capped = (value > SLOTS) ? SLOTS : value;
            if (capped >= fill_mark)
                cap_limit = value;
        end
        else if (idx == REG_RESERVED)
        begin
            rsv_count = int'(data[RSV_W-1:0]);
            clear_table();
        end
    endfunction

    // Applies one item to the shadow tables and returns the result it causes.
    function automatic psa_rsp_t allocate_or_free(input psa_req_t item);
        psa_rsp_t    res;
        int unsigned h;
        int unsigned last;
        int unsigned hole;
        int unsigned owner;
        res        = '0;
        res.status = ST_OK;
        h          = int'(item.handle);
        if (item.op == OP_ALLOC)
        begin
            if (handle_live[h])
            begin
                res.status = ST_ALREADY;
                res.slot   = slot_of_handle[h][SLOT_OUT_W-1:0];
            end
            else if (fill_mark >= usable_slots())
            begin
                res.status = ST_FULL;
            end
            else
            begin
                res.slot                      = SLOT_OUT_W'(fill_mark);
                handle_live[h]                = 1'b1;
                slot_of_handle[h]             = SLOT_W'(fill_mark);
                owner_of_slot[fill_mark % SLOTS] = item.handle;
                fill_mark                     = fill_mark + 1;
            end
        end
        else
        begin
            if (!handle_live[h] || fill_mark == 0)
            begin
                res.status = ST_NOT_ALLOC;
            end
            else
            begin
                // The last occupied slot's owner fills the hole unless the hole is last.
                last              = fill_mark - 1;
                hole              = int'(slot_of_handle[h]);
                res.slot          = SLOT_OUT_W'(hole);
                handle_live[h]    = 1'b0;
                slot_of_handle[h] = '0;
                if (hole != last)
                begin
                    owner                       = int'(owner_of_slot[last % SLOTS]);
                    owner_of_slot[hole % SLOTS] = HANDLE_W'(owner);
                    slot_of_handle[owner]       = SLOT_W'(hole);
                    res.moved                   = 1'b1;
                    res.moved_handle            = HANDLE_W'(owner);
                end
                fill_mark = last;
            end
        end
        res.fill_level = SLOT_W'(fill_mark);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Configuration, then the result leaving, then the item entering, all at one edge.
    always @(posedge clk or negedge rst_n)
    begin
        psa_rsp_t want;
        if (!rst_n)
        begin
            cap_limit = int'(CAP_RESET);
            rsv_count = int'(RSV_RESET);
            for (int i = 0; i < SLOTS; i++)
                owner_of_slot[i] = '0;
            clear_table();
            owed_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                write_register(cfg_index, cfg_data);

            if (rsp_valid && !rsp_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got status %0d slot %0d",
                             $time, rsp.status, rsp.slot);
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("slot", 16'(want.slot), 16'(rsp.slot));
                    check_field("moved", 16'(want.moved), 16'(rsp.moved));
                    check_field("moved_handle", 16'(want.moved_handle), 16'(rsp.moved_handle));
                    check_field("fill_level", 16'(want.fill_level), 16'(rsp.fill_level));
                end
            end

            if (req_valid && !req_stall)
                owed_results.push_back(allocate_or_free(req));

            pending = owed_results.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the packed slot allocator: clock, reset, stimulus and verdict.
module tb_top;
    import psa_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    psa_req_t              req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    psa_rsp_t              rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    packed_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psa_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // The result side stalls at random, or for a long stretch when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Ends the run when nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one item after a random gap and holds it until it is taken.
    task automatic send_item(input logic op, input logic [HANDLE_W-1:0] h);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{op: op, handle: h};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering until every owed result has come back, then waits a little more.
    task automatic drain(input int extra);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly items on a small pool of handles so that frees find live handles and
    // the table fills; about one item in ten is noise over the whole handle range.
    task automatic run_random(input int count, input logic [HANDLE_W-1:0] base,
                              input int pool_bits, input int alloc_pct);
        logic                op;
        logic [HANDLE_W-1:0] h;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                op = ($urandom_range(0, 1) == 0) ? OP_ALLOC : OP_FREE;
                h  = HANDLE_W'($urandom_range(0, 1023));
            end
            else
            begin
                op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
                h  = base ^ HANDLE_W'($urandom_range(0, (1 << pool_bits) - 1));
            end
            send_item(op, h);
        end
    endtask

    initial
    begin
        logic [HANDLE_W-1:0] base;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 87;

        // Directed: allocate, repeat allocate, and frees with and without a move.
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_ALLOC, 10'd1023);
        send_item(OP_ALLOC, 10'h2AA);
        send_item(OP_ALLOC, 10'h155);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_FREE, 10'd0);
        send_item(OP_FREE, 10'd0);
        send_item(OP_FREE, 10'h155);
        send_item(OP_FREE, 10'h2AA);
        send_item(OP_FREE, 10'd1023);
        drain(8);

        // Largest reserved block: one free slot at the very top of the table.
        cfg_write(REG_RESERVED, 11'h7FF);
        send_item(OP_ALLOC, 10'd5);
        send_item(OP_ALLOC, 10'd6);
        send_item(OP_ALLOC, 10'd5);
        drain(8);

        // A capacity below the fill mark is refused, so the table stays full.
        cfg_write(REG_CAPACITY, 0);
        send_item(OP_ALLOC, 10'd7);
        send_item(OP_FREE, 10'd5);
        drain(8);

        // No reserved slots and zero capacity: nothing can be allocated.
        cfg_write(REG_RESERVED, 0);
        cfg_write(REG_CAPACITY, 0);
        send_item(OP_ALLOC, 10'd7);
        send_item(OP_FREE, 10'd7);
        drain(8);

        // Capacity above the table depth acts as the full table.
        cfg_write(REG_CAPACITY, 2047);
        send_item(OP_ALLOC, 10'd9);
        send_item(OP_FREE, 10'd9);
        drain(8);

        // Capacity of one slot.
        cfg_write(REG_CAPACITY, 1);
        send_item(OP_ALLOC, 10'd3);
        send_item(OP_ALLOC, 10'd4);
        send_item(OP_FREE, 10'd4);
        drain(8);

        // Small table with a few reserved slots; the sender pauses midway.
        cfg_write(REG_CAPACITY, 24);
        cfg_write(REG_RESERVED, 3);
        base = HANDLE_W'($urandom_range(0, 1023));
        run_random(160, base, 5, 55);
        drain(1);
        run_random(170, base, 5, 55);
        drain(8);

        // Capacity write of one, refused while the fill mark is above one, then a wide open table.
        send_idle_pct = 87;
        recv_idle_pct = 8;
        cfg_write(REG_CAPACITY, 1);
        cfg_write(REG_CAPACITY, 2047);
        cfg_write(REG_RESERVED, 0);
        base = HANDLE_W'($urandom_range(0, 1023));
        run_random(330, base, 7, 65);
        drain(8);

        // Slots near the top of the table; the result side holds off for a while.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_write(REG_CAPACITY, 1010);
        cfg_write(REG_RESERVED, 1000);
        base = HANDLE_W'($urandom_range(0, 1023));
        run_random(120, base, 4, 50);
        hold_left = HOLD_CYCLES;
        run_random(210, base, 4, 50);
        drain(20);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
src/psa_pkg.sv
src/psa_ram.sv
src/packed_slot_allocator.sv
sim/psa_checker.sv
sim/tb_top.sv
